// ===== rtl/core/rf_sample_format_repacker_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef RF_SAMPLE_FORMAT_REPACKER_UNIT_DEFINES_SVH
`define RF_SAMPLE_FORMAT_REPACKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RSFR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rsfr_pkg.sv =====
`default_nettype none

package rsfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = 10;
    localparam int GROUP_N     = 4;
    localparam int GATHER_W    = 32;
    localparam int SGATHER_W   = 30;
    localparam int GROUP_W     = 40;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IN_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OUT_MODE = 1'b1;

    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [SAMPLE_W-1:0] sample_t;

    // One queue entry: four samples (index 0 first) or a single sample in slot 0.
    typedef struct packed {
        logic [GROUP_N-1:0][SAMPLE_W-1:0] samples;
        logic                             quad;
    } grp_t;

    // Mode bit and clear strobe handed to each half.
    typedef struct packed {
        logic mode_packed;
        logic clr;
    } ctl_t;

    // Signed 16-bit word -> trunc(w / 64) + 512
    function automatic sample_t word_to_sample(input logic [15:0] w);
        logic [15:0] t;
        logic [9:0]  q;
        t = w + (w[15] ? 16'd63 : 16'd0);
        q = t[15:6];
        return {~q[9], q[8:0]};
    endfunction

    // (s - 512) * 64 as 16-bit little-endian
    function automatic byte_t sample_lo(input sample_t s);
        return {s[1:0], 6'b0};
    endfunction

    function automatic byte_t sample_hi(input sample_t s);
        return {~s[9], s[8:2]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rsfr_if.sv =====
`default_nettype none

interface rsfr_in_if import rsfr_pkg::*;
    ;
    logic  valid;
    logic  ready;
    byte_t in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface rsfr_out_if import rsfr_pkg::*;
    ;
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rsfr_front.sv =====
`default_nettype none

module rsfr_front import rsfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rsfr_in_if.sink    raw_bytes,
    input  wire ctl_t  ctl,
    output grp_t       grp,
    output logic       grp_valid,
    input  wire logic  grp_ready
);

    logic [GATHER_W-1:0] gather_reg, gather_next;
    logic [2:0]          phase_reg, phase_next;
    logic                complete;
    logic                xfer;
    logic [GROUP_W-1:0]  g;

    assign complete        = ctl.mode_packed ? (phase_reg >= 3'd4) : (phase_reg != 3'd0);
    assign raw_bytes.ready = grp_ready || !complete;
    assign xfer            = raw_bytes.valid && raw_bytes.ready;
    assign g               = {gather_reg, raw_bytes.in_byte};
    assign grp_valid       = xfer && complete;

    always_comb
    begin
        grp.quad = ctl.mode_packed;
        if (ctl.mode_packed)
        begin
            grp.samples[0] = g[39:30];
            grp.samples[1] = g[29:20];
            grp.samples[2] = g[19:10];
            grp.samples[3] = g[9:0];
        end
        else
        begin
            grp.samples[0] = word_to_sample({raw_bytes.in_byte, gather_reg[7:0]});
            grp.samples[1] = '0;
            grp.samples[2] = '0;
            grp.samples[3] = '0;
        end
    end

    always_comb
    begin
        gather_next = gather_reg;
        phase_next  = phase_reg;
        if (ctl.clr)
        begin
            gather_next = '0;
            phase_next  = '0;
        end
        else if (xfer)
        begin
            if (complete)
            begin
                gather_next = '0;
                phase_next  = '0;
            end
            else if (ctl.mode_packed)
            begin
                gather_next = {gather_reg[GATHER_W-BYTE_W-1:0], raw_bytes.in_byte};
                phase_next  = phase_reg + 3'd1;
            end
            else
            begin
                gather_next = {{(GATHER_W-BYTE_W){1'b0}}, raw_bytes.in_byte};
                phase_next  = 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg <= '0;
            phase_reg  <= '0;
        end
        else
        begin
            gather_reg <= gather_next;
            phase_reg  <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rsfr_queue.sv =====
`default_nettype none

module rsfr_queue import rsfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire grp_t push_data,
    output logic      full,
    output logic      head_valid,
    output grp_t      head,
    input  wire logic pop
);

    grp_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rsfr_back.sv =====
`default_nettype none

module rsfr_back import rsfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire ctl_t  ctl,
    input  wire logic  head_valid,
    input  wire grp_t  head,
    output logic       pop,
    rsfr_out_if.source conv_bytes
);

    logic [SGATHER_W-1:0] sg_reg, sg_next;
    logic [1:0]           sp_reg, sp_next;
    logic [1:0]           idx_reg, idx_next;
    logic [GROUP_W-1:0]   shift_reg, shift_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 last_reg, last_next;

    sample_t s;
    logic    end_of_entry;
    logic    produces;
    logic    ser_free;
    logic    step;
    logic    out_xfer;

    assign s            = head.samples[idx_reg];
    assign end_of_entry = !head.quad || (idx_reg == 2'd3);
    assign produces     = !ctl.mode_packed || (sp_reg == 2'd3);
    assign out_xfer     = conv_bytes.valid && conv_bytes.ready;
    assign ser_free     = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && conv_bytes.ready);
    assign step         = head_valid && (!produces || ser_free);
    assign pop          = step && end_of_entry;

    assign conv_bytes.valid       = (cnt_reg != 3'd0);
    assign conv_bytes.out_byte    = shift_reg[GROUP_W-1 -: BYTE_W];
    assign conv_bytes.last_of_run = last_reg && (cnt_reg == 3'd1);

    always_comb
    begin
        sg_next    = sg_reg;
        sp_next    = sp_reg;
        idx_next   = idx_reg;
        shift_next = shift_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;

        if (out_xfer)
        begin
            shift_next = {shift_reg[GROUP_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            cnt_next   = cnt_reg - 3'd1;
        end

        if (ctl.clr)
        begin
            sg_next  = '0;
            sp_next  = '0;
            idx_next = '0;
        end
        else if (step)
        begin
            idx_next = end_of_entry ? 2'd0 : idx_reg + 2'd1;
            if (ctl.mode_packed)
            begin
                if (sp_reg == 2'd3)
                begin
                    shift_next = {sg_reg, s};
                    cnt_next   = 3'd5;
                    last_next  = 1'b1;
                    sg_next    = '0;
                    sp_next    = '0;
                end
                else
                begin
                    sg_next = {sg_reg[SGATHER_W-SAMPLE_W-1:0], s};
                    sp_next = sp_reg + 2'd1;
                end
            end
            else
            begin
                shift_next = {sample_lo(s), sample_hi(s), {(GROUP_W-2*BYTE_W){1'b0}}};
                cnt_next   = 3'd2;
                last_next  = end_of_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_reg  <= '0;
            sp_reg  <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            sg_reg  <= sg_next;
            sp_reg  <= sp_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rf_sample_format_repacker_unit.sv =====
// Path: the input transfer that completes a group writes it into the queue; the back end then
// steps through the queued samples and loads its output shift register on the one that fills a group.
// Throughput: one input byte per cycle unless the queue is full, one output byte per cycle while
// the output is ready; the output side sets the pace (packed in, word out gives 8 bytes per 5 in).
// A two-entry sample-group queue decouples input gathering from output serialization.
// Reset: async active low; both modes packed, all held partial groups dropped.
`default_nettype none

module rf_sample_format_repacker_unit import rsfr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    rsfr_in_if.sink                    raw_bytes,
    rsfr_out_if.source                 conv_bytes,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic in_mode_reg, out_mode_reg;
    ctl_t front_ctl, back_ctl;
    grp_t grp, head;
    logic grp_valid, q_full, head_valid, pop;

    assign front_ctl.mode_packed = in_mode_reg;
    assign front_ctl.clr         = cfg_we && (cfg_index == CFG_IDX_IN_MODE);
    assign back_ctl.mode_packed  = out_mode_reg;
    assign back_ctl.clr          = cfg_we && (cfg_index == CFG_IDX_OUT_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_mode_reg  <= 1'b1;
            out_mode_reg <= 1'b1;
        end
        else
        begin
            if (front_ctl.clr)
                in_mode_reg <= cfg_data[0];
            if (back_ctl.clr)
                out_mode_reg <= cfg_data[0];
        end
    end

    rsfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .raw_bytes (raw_bytes),
        .ctl       (front_ctl),
        .grp       (grp),
        .grp_valid (grp_valid),
        .grp_ready (!q_full)
    );

    rsfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (grp_valid),
        .push_data  (grp),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    rsfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (back_ctl),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .conv_bytes (conv_bytes)
    );

endmodule

`default_nettype wire

// ===== rtl/core/rsfr_checker.sv =====
`default_nettype none
`include "rf_sample_format_repacker_unit_defines.svh"

module rsfr_checker import rsfr_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire byte_t                 out_byte,
    input wire logic                  last_of_run,
    input wire logic                  cfg_we,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic       out_packed_reg;
    logic [1:0] in_cnt_reg;
    logic [2:0] run_cnt_reg;
    logic       in_xfer, out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_packed_reg <= 1'b1;
            in_cnt_reg     <= '0;
            run_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_IDX_OUT_MODE))
                out_packed_reg <= cfg_data[0];
            if (in_xfer && (in_cnt_reg != 2'd2))
                in_cnt_reg <= in_cnt_reg + 2'd1;
            if (out_xfer)
                run_cnt_reg <= last_of_run ? 3'd0
                             : ((run_cnt_reg == 3'd7) ? run_cnt_reg : run_cnt_reg + 3'd1);
        end
    end

    `RSFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                      out_valid && $stable(out_byte) && $stable(last_of_run),
                      "stalled output changed")
    `RSFR_ASSERT_IMPL(a_out_after_input, out_valid, in_cnt_reg == 2'd2,
                      "output before two input transfers")
    `RSFR_ASSERT_IMPL(a_packed_run, out_xfer && last_of_run && out_packed_reg,
                      run_cnt_reg == 3'd4, "packed run not five bytes")
    `RSFR_ASSERT_IMPL(a_word_run, out_xfer && last_of_run && !out_packed_reg,
                      run_cnt_reg == 3'd1 || run_cnt_reg == 3'd7,
                      "word run not two or eight bytes")

endmodule

bind rf_sample_format_repacker_unit rsfr_checker u_rsfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (raw_bytes.valid),
    .in_ready    (raw_bytes.ready),
    .out_valid   (conv_bytes.valid),
    .out_ready   (conv_bytes.ready),
    .out_byte    (conv_bytes.out_byte),
    .last_of_run (conv_bytes.last_of_run),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
);

`default_nettype wire
